FILE: hdl/c2pq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2pq_pkg
// Shared types, constants and the arctangent table for the cartesian to
// polar CORDIC.
// ----------------------------------------------------------------------------
package c2pq_pkg;

  localparam int DEF_COORD_WIDTH   = 16;
  localparam int DEF_CORDIC_STAGES = 16;

  localparam int GUARD_BITS   = 16;
  localparam int ANGLE_FRAC   = 16;
  localparam int ANGLE_WIDTH  = 16;
  localparam int QUAD_WIDTH   = 3;
  localparam int Z_WIDTH      = 26;
  localparam int GAIN_WIDTH   = 30;
  localparam int ROUND_SHIFT  = ANGLE_FRAC - 7;

  localparam logic [GAIN_WIDTH-1:0] GAIN_Q30 = 30'd652032874;

  localparam logic signed [ANGLE_WIDTH-1:0] HALF_TURN_Q7    = 16'sd23040;
  localparam logic signed [ANGLE_WIDTH-1:0] QUARTER_TURN_Q7 = 16'sd11520;
  localparam logic signed [Z_WIDTH-1:0]     HALF_TURN_Z     = 26'sd11796480;
  localparam logic signed [Z_WIDTH-1:0]     ROUND_HALF_Z    = 26'sd256;

  typedef enum logic [QUAD_WIDTH-1:0] {
    QUAD_AXIS = 3'd0,
    QUAD_1    = 3'd1,
    QUAD_2    = 3'd2,
    QUAD_3    = 3'd3,
    QUAD_4    = 3'd4
  } quad_e;

  typedef enum logic [1:0] {
    BASE_ZERO = 2'd0,
    BASE_POS  = 2'd1,
    BASE_NEG  = 2'd2
  } base_e;

  typedef logic signed [Z_WIDTH-1:0] zacc_t;

  // control travelling alongside each word through the chain
  typedef struct packed {
    logic                           valid;
    quad_e                          quad;
    logic                           special;
    base_e                          base;
    logic signed [ANGLE_WIDTH-1:0]  spec_angle;
  } side_t;

  // atan(2^-i) in degrees, scaled by 2^16
  function automatic zacc_t atan_q16(input logic [4:0] idx);
    zacc_t r;
    r = '0;
    unique case (idx)
      5'd0:    r = 26'sd2949120;
      5'd1:    r = 26'sd1740967;
      5'd2:    r = 26'sd919879;
      5'd3:    r = 26'sd466945;
      5'd4:    r = 26'sd234379;
      5'd5:    r = 26'sd117304;
      5'd6:    r = 26'sd58666;
      5'd7:    r = 26'sd29335;
      5'd8:    r = 26'sd14668;
      5'd9:    r = 26'sd7334;
      5'd10:   r = 26'sd3667;
      5'd11:   r = 26'sd1833;
      5'd12:   r = 26'sd917;
      5'd13:   r = 26'sd458;
      5'd14:   r = 26'sd229;
      5'd15:   r = 26'sd115;
      5'd16:   r = 26'sd57;
      5'd17:   r = 26'sd29;
      5'd18:   r = 26'sd14;
      5'd19:   r = 26'sd7;
      5'd20:   r = 26'sd4;
      5'd21:   r = 26'sd2;
      5'd22:   r = 26'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/cartesian_to_polar_quadrant_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartesian_to_polar_quadrant_core
// Pipelined vectoring CORDIC: point (x, y) in Q8.8 to quadrant, radius in
// Q8.8 and angle in degrees in Q9.7.
//
// One word in on s_axis: x in the low COORD_WIDTH bits, y above it.
// One word out on m_axis per input word: quadrant, radius, angle.
// The chain is one entry cell, one cell per micro-rotation, then gain
// removal and the output register. Throughput is one word per cycle
// while not stalled; a new word may then enter every cycle.
// The whole chain advances together; it stalls only when the output
// register holds a word that m_axis_tready does not take, and
// s_axis_tready then falls in the same cycle.
// Reset empties the chain; no word is held afterwards. There is no
// other state.
// ----------------------------------------------------------------------------
module cartesian_to_polar_quadrant_core #(
  parameter int COORD_WIDTH   = c2pq_pkg::DEF_COORD_WIDTH,
  parameter int CORDIC_STAGES = c2pq_pkg::DEF_CORDIC_STAGES,
  parameter int IN_TW         = ((2 * COORD_WIDTH + 7) / 8) * 8,
  parameter int OUT_TW        =
    ((c2pq_pkg::QUAD_WIDTH + COORD_WIDTH + c2pq_pkg::ANGLE_WIDTH + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_TW-1:0]  s_axis_tdata,   // coord_x, coord_y
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_TW-1:0] m_axis_tdata    // quadrant, radius, angle_deg
);
  import c2pq_pkg::*;

  localparam int XW = COORD_WIDTH + GUARD_BITS + 3;
  localparam int QW = QUAD_WIDTH;
  localparam int AW = ANGLE_WIDTH;

  logic                          en;
  logic signed [XW-1:0]          x_w [0:CORDIC_STAGES];
  logic signed [XW-1:0]          y_w [0:CORDIC_STAGES];
  zacc_t                         z_w [0:CORDIC_STAGES];
  side_t                         side_w [0:CORDIC_STAGES];
  quad_e                         quad;
  logic [COORD_WIDTH-1:0]        radius;
  logic signed [AW-1:0]          angle;
  logic                          out_valid;

  assign en            = !out_valid || m_axis_tready;
  assign s_axis_tready = en;
  assign z_w[0]        = '0;

  c2pq_prep #(
    .COORD_WIDTH (COORD_WIDTH),
    .XW          (XW)
  ) u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (s_axis_tvalid),
    .coord_x_i (s_axis_tdata[COORD_WIDTH-1:0]),
    .coord_y_i (s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .x_o       (x_w[0]),
    .y_o       (y_w[0]),
    .side_o    (side_w[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    c2pq_cell #(
      .XW    (XW),
      .SHIFT (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .x_i    (x_w[g]),
      .y_i    (y_w[g]),
      .z_i    (z_w[g]),
      .side_i (side_w[g]),
      .x_o    (x_w[g+1]),
      .y_o    (y_w[g+1]),
      .z_o    (z_w[g+1]),
      .side_o (side_w[g+1])
    );
  end

  c2pq_post #(
    .COORD_WIDTH (COORD_WIDTH),
    .XW          (XW)
  ) u_post (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .x_i      (x_w[CORDIC_STAGES]),
    .z_i      (z_w[CORDIC_STAGES]),
    .side_i   (side_w[CORDIC_STAGES]),
    .valid_o  (out_valid),
    .quad_o   (quad),
    .radius_o (radius),
    .angle_o  (angle)
  );

  assign m_axis_tvalid = out_valid;

  always_comb begin
    m_axis_tdata                                 = '0;
    m_axis_tdata[QW-1:0]                         = quad;
    m_axis_tdata[QW+COORD_WIDTH-1:QW]            = radius;
    m_axis_tdata[QW+COORD_WIDTH+AW-1:QW+COORD_WIDTH] = angle;
  end

endmodule

FILE: hdl/c2pq_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2pq_prep
// Entry cell: quadrant, axis and origin cases, half-plane fold and guard
// bit scaling ahead of the rotation chain.
// ----------------------------------------------------------------------------
module c2pq_prep #(
  parameter int COORD_WIDTH = c2pq_pkg::DEF_COORD_WIDTH,
  parameter int XW          = COORD_WIDTH + c2pq_pkg::GUARD_BITS + 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [COORD_WIDTH-1:0] coord_x_i,
  input  logic signed [COORD_WIDTH-1:0] coord_y_i,
  output logic signed [XW-1:0]          x_o,
  output logic signed [XW-1:0]          y_o,
  output c2pq_pkg::side_t               side_o
);
  import c2pq_pkg::*;

  logic signed [XW-1:0] xe, ye, x_d, y_d, x_q, y_q;
  side_t                side_d, side_q;
  logic                 x_zero, y_zero, x_neg, y_neg;

  always_comb begin
    xe     = {{(XW-COORD_WIDTH){coord_x_i[COORD_WIDTH-1]}}, coord_x_i};
    ye     = {{(XW-COORD_WIDTH){coord_y_i[COORD_WIDTH-1]}}, coord_y_i};
    x_zero = (coord_x_i == '0);
    y_zero = (coord_y_i == '0);
    x_neg  = coord_x_i[COORD_WIDTH-1];
    y_neg  = coord_y_i[COORD_WIDTH-1];

    side_d            = '0;
    side_d.valid      = valid_i;
    side_d.quad       = QUAD_AXIS;
    side_d.base       = BASE_ZERO;
    side_d.spec_angle = '0;
    if (!x_zero && !y_zero) begin
      priority if (!x_neg && !y_neg) side_d.quad = QUAD_1;
      else if (x_neg && !y_neg)      side_d.quad = QUAD_2;
      else if (x_neg && y_neg)       side_d.quad = QUAD_3;
      else                           side_d.quad = QUAD_4;
    end

    x_d = '0;
    y_d = '0;
    priority if (x_zero && y_zero) begin
      side_d.special = 1'b1;
    end else if (y_zero) begin
      side_d.special    = 1'b1;
      x_d               = (x_neg ? -xe : xe) <<< GUARD_BITS;
      side_d.spec_angle = x_neg ? HALF_TURN_Q7 : '0;
    end else if (x_zero) begin
      side_d.special    = 1'b1;
      x_d               = (y_neg ? -ye : ye) <<< GUARD_BITS;
      side_d.spec_angle = y_neg ? -QUARTER_TURN_Q7 : QUARTER_TURN_Q7;
    end else if (x_neg) begin
      side_d.base = y_neg ? BASE_NEG : BASE_POS;
      x_d         = (-xe) <<< GUARD_BITS;
      y_d         = (-ye) <<< GUARD_BITS;
    end else begin
      x_d = xe <<< GUARD_BITS;
      y_d = ye <<< GUARD_BITS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign side_o = side_q;

endmodule

FILE: hdl/c2pq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2pq_cell
// One vectoring micro-rotation of the CORDIC chain, registered.
// ----------------------------------------------------------------------------
module c2pq_cell #(
  parameter int XW    = 35,
  parameter int SHIFT = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic signed [XW-1:0]  x_i,
  input  logic signed [XW-1:0]  y_i,
  input  c2pq_pkg::zacc_t       z_i,
  input  c2pq_pkg::side_t       side_i,
  output logic signed [XW-1:0]  x_o,
  output logic signed [XW-1:0]  y_o,
  output c2pq_pkg::zacc_t       z_o,
  output c2pq_pkg::side_t       side_o
);
  import c2pq_pkg::*;

  localparam zacc_t ATAN = atan_q16(5'(SHIFT));

  logic signed [XW-1:0] xs, ys, x_d, y_d, x_q, y_q;
  zacc_t                z_d, z_q;
  side_t                side_q;
  logic                 y_pos;

  always_comb begin
    xs    = x_i >>> SHIFT;
    ys    = y_i >>> SHIFT;
    y_pos = !y_i[XW-1] && (y_i != '0);
    x_d   = x_i;
    y_d   = y_i;
    z_d   = z_i;
    // axis and origin words pass untouched
    if (!side_i.special) begin
      if (y_pos) begin
        x_d = x_i + ys;
        y_d = y_i - xs;
        z_d = z_i + ATAN;
      end else begin
        x_d = x_i - ys;
        y_d = y_i + xs;
        z_d = z_i - ATAN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign side_o = side_q;

endmodule

FILE: hdl/c2pq_post.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2pq_post
// Gain removal, rounding and saturation of radius and angle in two
// registered steps, the second being the output register.
// ----------------------------------------------------------------------------
module c2pq_post #(
  parameter int COORD_WIDTH = c2pq_pkg::DEF_COORD_WIDTH,
  parameter int XW          = COORD_WIDTH + c2pq_pkg::GUARD_BITS + 3
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic signed [XW-1:0]                  x_i,
  input  c2pq_pkg::zacc_t                       z_i,
  input  c2pq_pkg::side_t                       side_i,
  output logic                                  valid_o,
  output c2pq_pkg::quad_e                       quad_o,
  output logic [COORD_WIDTH-1:0]                radius_o,
  output logic signed [c2pq_pkg::ANGLE_WIDTH-1:0] angle_o
);
  import c2pq_pkg::*;

  localparam int LO_W  = 15;
  localparam int HW    = XW - LO_W;
  localparam int HL    = HW / 2;
  localparam int HH    = HW - HL;
  localparam int PLW   = HL + GAIN_WIDTH;
  localparam int PHW   = HH + GAIN_WIDTH;
  localparam int LPW   = LO_W + GAIN_WIDTH;
  localparam int PW    = HW + GAIN_WIDTH + 1;
  localparam int RSH   = LO_W + GUARD_BITS;
  localparam int AQW   = Z_WIDTH - ROUND_SHIFT;

  localparam logic signed [AQW-1:0] ANG_MAX = AQW'(HALF_TURN_Q7);
  localparam logic signed [AQW-1:0] ANG_MIN = -AQW'(HALF_TURN_Q7);

  // first step
  logic [XW-1:0]                  u;
  logic [LPW-1:0]                 lo_full;
  logic [PLW-1:0]                 pl_d, pl_q;
  logic [PHW-1:0]                 ph_d, ph_q;
  logic [GAIN_WIDTH-1:0]          lo_d, lo_q;
  zacc_t                          total, total_r;
  logic signed [AQW-1:0]          aq;
  logic signed [ANGLE_WIDTH-1:0]  ang_d, ang_q;
  logic [COORD_WIDTH-1:0]         srad_q;
  logic                           v1_q, spec_q;
  quad_e                          quad1_q;

  // second step
  logic [PW-1:0]                  p, pr;
  logic [HW-1:0]                  rad_full;
  logic [COORD_WIDTH-1:0]         rad_d, rad_q;
  logic signed [ANGLE_WIDTH-1:0]  ang2_q;
  logic                           v2_q;
  quad_e                          quad2_q;

  always_comb begin
    u       = x_i[XW-1] ? '0 : XW'(x_i);
    lo_full = LPW'(u[LO_W-1:0]) * LPW'(GAIN_Q30);
    lo_d    = lo_full[LPW-1:LO_W];
    pl_d    = PLW'(u[LO_W+HL-1:LO_W]) * PLW'(GAIN_Q30);
    ph_d    = PHW'(u[XW-1:LO_W+HL]) * PHW'(GAIN_Q30);

    unique case (side_i.base)
      BASE_POS: total = z_i + HALF_TURN_Z;
      BASE_NEG: total = z_i - HALF_TURN_Z;
      default:  total = z_i;
    endcase
    total_r = total + ROUND_HALF_Z;
    aq      = total_r[Z_WIDTH-1:ROUND_SHIFT];
    priority if (aq > ANG_MAX) ang_d = HALF_TURN_Q7;
    else if (aq < ANG_MIN)     ang_d = -HALF_TURN_Q7;
    else                       ang_d = aq[ANGLE_WIDTH-1:0];
    if (side_i.special) begin
      ang_d = side_i.spec_angle;
    end
  end

  always_comb begin
    p        = (PW'(ph_q) << HL) + PW'(pl_q) + PW'(lo_q);
    pr       = p + (PW'(1) << (RSH - 1));
    rad_full = pr[PW-1:RSH];
    if (spec_q) begin
      rad_d = srad_q;
    end else if (rad_full[HW-1:COORD_WIDTH] != '0) begin
      rad_d = '1;
    end else begin
      rad_d = rad_full[COORD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= side_i.valid;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q    <= pl_d;
      ph_q    <= ph_d;
      lo_q    <= lo_d;
      ang_q   <= ang_d;
      spec_q  <= side_i.special;
      srad_q  <= x_i[GUARD_BITS+COORD_WIDTH-1:GUARD_BITS];
      quad1_q <= side_i.quad;
      rad_q   <= rad_d;
      ang2_q  <= ang_q;
      quad2_q <= quad1_q;
    end
  end

  assign valid_o  = v2_q;
  assign quad_o   = quad2_q;
  assign radius_o = rad_q;
  assign angle_o  = ang2_q;

endmodule

FILE: test/cartesian_to_polar_quadrant_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartesian_to_polar_quadrant_core_tb
// Self-checking bench for the CORDIC cartesian to polar converter. A table
// of corner points runs first: origin, both axes, the extremes of both
// coordinates and points near the +/-180 seam. Random points follow under
// four idling mixes on both stream sides. Each output word is compared
// field by field against the table value where given, else against a
// bit-exact CORDIC predictor held in the bench. One long output hold-off
// fills the pipeline, and the sender pauses until the pipeline drains.
// ----------------------------------------------------------------------------
module cartesian_to_polar_quadrant_core_tb;
  import c2pq_pkg::*;

  localparam int         CLK_HALF      = 5;
  localparam int         N_STAGES      = 16;
  localparam int         PIPE_DEPTH    = N_STAGES + 3;
  localparam int         PHASE_POINTS  = 500;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         CYCLE_LIMIT   = 200000;
  localparam int         N_PROBES      = 24;
  localparam longint     DEG180_Q16    = 180 * 65536;
  localparam bit [63:0]  CORDIC_GAIN   = 64'd652032874;
  localparam int         ANGLE_LIMIT   = 23040;

  typedef struct {
    quad_e                quad;
    logic [15:0]          radius;
    logic signed [15:0]   angle;
  } polar_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               known;
    logic [2:0]         quad;
    logic [15:0]        radius;
    logic signed [15:0] angle;
  } probe_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // coord_x, coord_y
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // quadrant, radius, angle_deg

  polar_t polar_expect_q[$];
  int     err_cnt;
  int     cycle_cnt;
  int     src_idle_pct;
  int     snk_stall_pct;
  bit     rx_hold_start;
  int     rx_hold_left;

  longint atan_deg_q16 [0:31] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0,
    0, 0, 0, 0, 0, 0, 0, 0
  };

  // corner points, expected values given only where they are obvious
  probe_t probes [N_PROBES] = '{
    '{0,      0,      1'b1, QUAD_AXIS, 0,     0},
    '{32767,  0,      1'b1, QUAD_AXIS, 32767, 0},
    '{-32768, 0,      1'b1, QUAD_AXIS, 32768, 23040},
    '{1,      0,      1'b1, QUAD_AXIS, 1,     0},
    '{-1,     0,      1'b1, QUAD_AXIS, 1,     23040},
    '{0,      32767,  1'b1, QUAD_AXIS, 32767, 11520},
    '{0,      -32768, 1'b1, QUAD_AXIS, 32768, -11520},
    '{0,      1,      1'b1, QUAD_AXIS, 1,     11520},
    '{0,      -1,     1'b1, QUAD_AXIS, 1,     -11520},
    '{256,    256,    1'b0, QUAD_AXIS, 0,     0},
    '{32767,  32767,  1'b0, QUAD_AXIS, 0,     0},
    '{-32768, 32767,  1'b0, QUAD_AXIS, 0,     0},
    '{-32768, -32768, 1'b0, QUAD_AXIS, 0,     0},
    '{32767,  -32768, 1'b0, QUAD_AXIS, 0,     0},
    '{1,      1,      1'b0, QUAD_AXIS, 0,     0},
    '{-1,     1,      1'b0, QUAD_AXIS, 0,     0},
    '{-1,     -1,     1'b0, QUAD_AXIS, 0,     0},
    '{1,      -1,     1'b0, QUAD_AXIS, 0,     0},
    '{-32768, 1,      1'b0, QUAD_AXIS, 0,     0},
    '{-32768, -1,     1'b0, QUAD_AXIS, 0,     0},
    '{32767,  1,      1'b0, QUAD_AXIS, 0,     0},
    '{1,      32767,  1'b0, QUAD_AXIS, 0,     0},
    '{-1,     -32768, 1'b0, QUAD_AXIS, 0,     0},
    '{-21846, 21845,  1'b0, QUAD_AXIS, 0,     0}
  };

  cartesian_to_polar_quadrant_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #CLK_HALF clk_i = ~clk_i;

  function automatic polar_t predict_polar(input logic signed [15:0] px,
                                           input logic signed [15:0] py);
    polar_t    res;
    longint    cx;
    longint    cy;
    longint    cz;
    longint    xs;
    longint    ys;
    longint    base_q16;
    longint    ang;
    bit [63:0] mag;
    bit [63:0] prod;
    bit [63:0] rad;
    cx       = px;
    cy       = py;
    cz       = 0;
    base_q16 = 0;
    if (cx == 0 || cy == 0) begin
      res.quad = QUAD_AXIS;
    end else if (cx > 0) begin
      if (cy > 0) res.quad = QUAD_1;
      else        res.quad = QUAD_4;
    end else begin
      if (cy > 0) res.quad = QUAD_2;
      else        res.quad = QUAD_3;
    end
    if (cx == 0 && cy == 0) begin
      res.radius = '0;
      res.angle  = '0;
      return res;
    end
    if (cy == 0) begin
      res.radius = (cx < 0) ? 16'(-cx) : 16'(cx);
      res.angle  = (cx < 0) ? 16'(ANGLE_LIMIT) : 16'sd0;
      return res;
    end
    if (cx == 0) begin
      res.radius = (cy < 0) ? 16'(-cy) : 16'(cy);
      res.angle  = (cy < 0) ? 16'(-ANGLE_LIMIT / 2) : 16'(ANGLE_LIMIT / 2);
      return res;
    end
    // left half plane: turn by a half circle first
    if (cx < 0) begin
      base_q16 = (cy >= 0) ? DEG180_Q16 : -DEG180_Q16;
      cx       = -cx;
      cy       = -cy;
    end
    cx = cx * 65536;
    cy = cy * 65536;
    for (int i = 0; i < N_STAGES; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (cy > 0) begin
        cx = cx + ys;
        cy = cy - xs;
        cz = cz + atan_deg_q16[i];
      end else begin
        cx = cx - ys;
        cy = cy + xs;
        cz = cz - atan_deg_q16[i];
      end
    end
    mag  = (cx > 0) ? 64'(cx) : 64'd0;
    prod = (mag >> 15) * CORDIC_GAIN + (((mag & 64'h7FFF) * CORDIC_GAIN) >> 15);
    rad  = (prod + (64'd1 << 30)) >> 31;
    res.radius = (rad > 64'd65535) ? 16'hFFFF : rad[15:0];
    ang = (base_q16 + cz + 256) >>> 9;
    if (ang > ANGLE_LIMIT)  ang = ANGLE_LIMIT;
    if (ang < -ANGLE_LIMIT) ang = -ANGLE_LIMIT;
    res.angle = ang[15:0];
    return res;
  endfunction

  function automatic logic signed [15:0] extreme_coord();
    logic signed [15:0] v;
    case ($urandom_range(5))
      0:       v = 16'sh8000;
      1:       v = 16'sh8001;
      2:       v = -16'sd1;
      3:       v = 16'sd0;
      4:       v = 16'sd1;
      default: v = 16'sh7FFF;
    endcase
    return v;
  endfunction

  task automatic drive_point(input logic signed [15:0] px, input logic signed [15:0] py,
                             input logic known, input polar_t typed);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {py, px};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (known) polar_expect_q.push_back(typed);
    else       polar_expect_q.push_back(predict_polar(px, py));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (polar_expect_q.size() != 0);
  endtask

  // output side: random stalls, or a long hold-off on request
  always @(posedge clk_i) begin
    if (rx_hold_start) begin
      rx_hold_start = 1'b0;
      rx_hold_left  = HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left  = rx_hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk_i) begin : chk_out
    polar_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (polar_expect_q.size() == 0) begin
        err_cnt = err_cnt + 1;
        $display("%0t: unexpected word, got q=%0d r=%0d a=%0d", $time,
                 m_axis_tdata[2:0], m_axis_tdata[18:3], $signed(m_axis_tdata[34:19]));
      end else begin
        want = polar_expect_q.pop_front();
        if (m_axis_tdata[2:0] !== want.quad || m_axis_tdata[18:3] !== want.radius ||
            m_axis_tdata[34:19] !== want.angle) begin
          err_cnt = err_cnt + 1;
          $display("%0t: mismatch, expected q=%0d r=%0d a=%0d, got q=%0d r=%0d a=%0d",
                   $time, want.quad, want.radius, want.angle, m_axis_tdata[2:0],
                   m_axis_tdata[18:3], $signed(m_axis_tdata[34:19]));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stim
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    polar_t             typed;
    err_cnt       = 0;
    cycle_cnt     = 0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    rx_hold_start = 1'b0;
    rx_hold_left  = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < N_PROBES; p++) begin
      typed.quad   = quad_e'(probes[p].quad);
      typed.radius = probes[p].radius;
      typed.angle  = probes[p].angle;
      drive_point(probes[p].x, probes[p].y, probes[p].known, typed);
    end
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1:       begin src_idle_pct = 67; snk_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  snk_stall_pct = 67; end
        default: begin src_idle_pct = 23; snk_stall_pct = 23; end
      endcase
      for (int k = 0; k < PHASE_POINTS; k++) begin
        if (ph == 0 && k == 200) rx_hold_start = 1'b1;
        if (k == 350) wait_drained();
        case ($urandom_range(9))
          4: begin
            rx = 16'($urandom_range(40) - 20);
            ry = 16'($urandom_range(40) - 20);
          end
          5: begin
            if ($urandom_range(1)) begin
              rx = 16'($urandom);
              ry = '0;
            end else begin
              rx = '0;
              ry = 16'($urandom);
            end
          end
          6: begin
            rx = extreme_coord();
            ry = extreme_coord();
          end
          7: begin
            // close to the negative x axis, across the half-circle seam
            rx = 16'(-$urandom_range(32768, 1));
            ry = 16'($urandom_range(6) - 3);
          end
          default: begin
            rx = 16'($urandom);
            ry = 16'($urandom);
          end
        endcase
        drive_point(rx, ry, 1'b0, typed);
      end
    end
    wait_drained();
    repeat (PIPE_DEPTH + 10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
